/* rtl/assert_macros.svh */
// Assertion macros shared by the sound generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/psg_pkg.sv */
// Shared constants and types of the pulse and saw sound generator.
package psg_pkg;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int VOL_W    = 4;
  localparam int DUTY_W   = 3;
  localparam int PERIOD_W = 12;
  localparam int TIMER_W  = 13;
  localparam int PHASE_W  = 4;
  localparam int RATE_W   = 6;
  localparam int SAW_W    = 8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [3:0] PAGE_PULSE_ONE = 4'h9;
  localparam logic [3:0] PAGE_PULSE_TWO = 4'hA;
  localparam logic [3:0] PAGE_SAW       = 4'hB;

  localparam logic [1:0] REG_CTRL      = 2'd0;
  localparam logic [1:0] REG_PERIOD_LO = 2'd1;
  localparam logic [1:0] REG_PERIOD_HI = 2'd2;

  localparam logic [PHASE_W-1:0] SAW_PHASE_END = 4'd14;

  typedef struct packed {
    logic ctrl;
    logic per_lo;
    logic per_hi;
  } psg_wr_t;

endpackage

/* rtl/pulse_saw_sound_generator.sv */
// Top level of the pulse and saw sound generator.
//
//   port group | direction | transfer when         | payload
//   in_        | in        | in_valid & !in_stall  | action, address, data
//   out_       | out       | out_valid & !out_stall| pulse_one/two_level, saw_level
//   cfg_       | in        | cfg_write_en          | line_swap
//
// One transfer per cycle on each side unless a stall holds it; each item yields one result.
// The item register feeds channel update logic that writes the result register.
// Reset is synchronous, active low; all channel state returns to its power-up values.
// A stalled result holds; the input stalls once the item register is also full.
`include "assert_macros.svh"
module pulse_saw_sound_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [psg_pkg::ADDR_W-1:0]  in_address,
  input  logic [psg_pkg::DATA_W-1:0]  in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [psg_pkg::VOL_W-1:0]   out_pulse_one_level,
  output logic [psg_pkg::VOL_W-1:0]   out_pulse_two_level,
  output logic [psg_pkg::SAW_W-1:0]   out_saw_level,
  input  logic                        cfg_write_en,
  input  logic                        cfg_wdata
);
  import psg_pkg::*;

  logic               line_swap_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_action_r;
  logic [ADDR_W-1:0]  s1_address_r;
  logic [DATA_W-1:0]  s1_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic [VOL_W-1:0]   p1_level_r, p2_level_r, p1_level_nxt, p2_level_nxt;
  logic [SAW_W-1:0]   saw_level_r, saw_level_nxt;
  logic               adv, tick, wr_en;
  psg_wr_t            wr_p1, wr_p2, wr_saw;

  assign in_stall      = s1_valid_r && out_valid_r && out_stall;
  assign adv           = s1_valid_r && !(out_valid_r && out_stall);
  assign tick          = adv && s1_action_r == ACT_TICK;
  assign wr_en         = adv && s1_action_r == ACT_WRITE;
  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  psg_decode u_decode (
    .wr_en        (wr_en),
    .address      (s1_address_r),
    .line_swap    (line_swap_r),
    .wr_pulse_one (wr_p1),
    .wr_pulse_two (wr_p2),
    .wr_saw       (wr_saw)
  );

  psg_pulse u_pulse_one (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .wr        (wr_p1),
    .data      (s1_data_r),
    .level_nxt (p1_level_nxt)
  );

  psg_pulse u_pulse_two (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .wr        (wr_p2),
    .data      (s1_data_r),
    .level_nxt (p2_level_nxt)
  );

  psg_saw u_saw (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .wr        (wr_saw),
    .data      (s1_data_r),
    .level_nxt (saw_level_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_swap_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        line_swap_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action_r  <= in_action;
      s1_address_r <= in_address;
      s1_data_r    <= in_data;
    end
    if (adv) begin
      p1_level_r  <= p1_level_nxt;
      p2_level_r  <= p2_level_nxt;
      saw_level_r <= saw_level_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_one_level = p1_level_r;
  assign out_pulse_two_level = p2_level_r;
  assign out_saw_level       = saw_level_r;

  `ASSERT_ALWAYS(a_stall_only_full, !in_stall || s1_valid_r, "input stalled with empty stage")
  `ASSERT_NEXT(a_adv_gives_result, adv, out_valid_r, "processed item left no result")
  `ASSERT_NEXT(a_no_adv_no_new, !adv && !out_stall, !out_valid_r, "result without item")

endmodule

/* rtl/psg_decode.sv */
// Register write decode with optional swap of address lines A0 and A1.
module psg_decode (
  input  logic                        wr_en,
  input  logic [psg_pkg::ADDR_W-1:0]  address,
  input  logic                        line_swap,
  output psg_pkg::psg_wr_t            wr_pulse_one,
  output psg_pkg::psg_wr_t            wr_pulse_two,
  output psg_pkg::psg_wr_t            wr_saw
);
  import psg_pkg::*;

  logic [1:0] lo;
  logic [3:0] page;
  psg_wr_t    sel;

  assign page = address[ADDR_W-1 -: 4];
  assign lo   = line_swap ? {address[0], address[1]} : address[1:0];

  always_comb begin
    sel = '0;
    case (lo)
      REG_CTRL:      sel.ctrl   = 1'b1;
      REG_PERIOD_LO: sel.per_lo = 1'b1;
      REG_PERIOD_HI: sel.per_hi = 1'b1;
      default:       sel        = '0;
    endcase
  end

  assign wr_pulse_one = (wr_en && page == PAGE_PULSE_ONE) ? sel : '0;
  assign wr_pulse_two = (wr_en && page == PAGE_PULSE_TWO) ? sel : '0;
  assign wr_saw       = (wr_en && page == PAGE_SAW)       ? sel : '0;

endmodule

/* rtl/psg_pulse.sv */
// One pulse channel: registers, divider timer, duty phase and output level.
`include "assert_macros.svh"
module psg_pulse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  psg_pkg::psg_wr_t            wr,
  input  logic [psg_pkg::DATA_W-1:0]  data,
  output logic [psg_pkg::VOL_W-1:0]   level_nxt
);
  import psg_pkg::*;

  logic [VOL_W-1:0]    volume_r, volume_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic                constant_r, constant_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                enable_r, enable_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt, timer_dec;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [VOL_W-1:0]    out_r, out_nxt;

  assign timer_dec = timer_r - 1'b1;

  always_comb begin
    volume_nxt   = volume_r;
    duty_nxt     = duty_r;
    constant_nxt = constant_r;
    period_nxt   = period_r;
    enable_nxt   = enable_r;
    timer_nxt    = timer_r;
    phase_nxt    = phase_r;
    out_nxt      = out_r;
    if (tick) begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        phase_nxt = phase_r + 1'b1;
        timer_nxt = {1'b0, period_r} + 1'b1;
        if (enable_r) begin
          out_nxt = (constant_r || phase_nxt <= {1'b0, duty_r}) ? volume_r : '0;
        end
      end
      if (!enable_r) begin
        out_nxt = '0;
      end
    end
    if (wr.ctrl) begin
      volume_nxt   = data[VOL_W-1:0];
      duty_nxt     = data[6:4];
      constant_nxt = data[7];
    end
    if (wr.per_lo) begin
      period_nxt[7:0] = data;
    end
    if (wr.per_hi) begin
      period_nxt[PERIOD_W-1:8] = data[3:0];
      enable_nxt               = data[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r   <= '0;
      duty_r     <= DUTY_W'(1);
      constant_r <= 1'b0;
      period_r   <= '0;
      enable_r   <= 1'b0;
      timer_r    <= TIMER_W'(1);
      phase_r    <= '0;
      out_r      <= '0;
    end else begin
      volume_r   <= volume_nxt;
      duty_r     <= duty_nxt;
      constant_r <= constant_nxt;
      period_r   <= period_nxt;
      enable_r   <= enable_nxt;
      timer_r    <= timer_nxt;
      phase_r    <= phase_nxt;
      out_r      <= out_nxt;
    end
  end

  assign level_nxt = out_nxt;

  `ASSERT_ALWAYS(a_pulse_timer_live, timer_r != '0, "pulse timer stuck at zero")
  `ASSERT_NEXT(a_pulse_off_silent, tick && !enable_r, out_r == '0, "disabled pulse not silent")

endmodule

/* rtl/psg_saw.sv */
// Sawtooth channel: registers, divider timer, 14-phase accumulator and level.
`include "assert_macros.svh"
module psg_saw (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  psg_pkg::psg_wr_t            wr,
  input  logic [psg_pkg::DATA_W-1:0]  data,
  output logic [psg_pkg::SAW_W-1:0]   level_nxt
);
  import psg_pkg::*;

  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                enable_r, enable_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt, timer_dec;
  logic [PHASE_W-1:0]  phase_r, phase_nxt, phase_inc;
  logic [SAW_W-1:0]    accum_r, accum_nxt, accum_add;
  logic [SAW_W-1:0]    out_r, out_nxt;

  assign timer_dec = timer_r - 1'b1;
  assign phase_inc = phase_r + 1'b1;
  assign accum_add = (phase_r != '0 && !phase_r[0]) ?
                     accum_r + {{(SAW_W-RATE_W){1'b0}}, rate_r} : accum_r;

  always_comb begin
    rate_nxt   = rate_r;
    period_nxt = period_r;
    enable_nxt = enable_r;
    timer_nxt  = timer_r;
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    out_nxt    = out_r;
    if (tick) begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        timer_nxt = {1'b0, period_r} + 1'b1;
        if (phase_inc == SAW_PHASE_END) begin
          phase_nxt = '0;
          accum_nxt = '0;
        end else begin
          phase_nxt = phase_inc;
          accum_nxt = accum_add;
        end
        if (enable_r) begin
          out_nxt = accum_nxt;
        end
      end
    end
    if (wr.ctrl) begin
      rate_nxt = data[RATE_W-1:0];
    end
    if (wr.per_lo) begin
      period_nxt[7:0] = data;
    end
    if (wr.per_hi) begin
      period_nxt[PERIOD_W-1:8] = data[3:0];
      enable_nxt               = data[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= '0;
      period_r <= '0;
      enable_r <= 1'b0;
      timer_r  <= TIMER_W'(1);
      phase_r  <= '0;
      accum_r  <= '0;
      out_r    <= '0;
    end else begin
      rate_r   <= rate_nxt;
      period_r <= period_nxt;
      enable_r <= enable_nxt;
      timer_r  <= timer_nxt;
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      out_r    <= out_nxt;
    end
  end

  assign level_nxt = out_nxt;

  `ASSERT_ALWAYS(a_saw_phase_range, phase_r < SAW_PHASE_END, "saw phase past cycle end")
  `ASSERT_ALWAYS(a_saw_timer_live, timer_r != '0, "saw timer stuck at zero")
  `ASSERT_NEXT(a_saw_off_hold, !enable_r, $stable(out_r), "disabled saw level moved")

endmodule

/* tb/pulse_saw_sound_generator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the pulse and saw sound generator.
module pulse_saw_sound_generator_tb;
  import psg_pkg::*;

  localparam logic [1:0] REG_UNUSED     = 2'd3;
  localparam logic [3:0] PAGE_NONE_LOW  = 4'h8;
  localparam logic [3:0] PAGE_NONE_HIGH = 4'hC;

  typedef struct packed {
    logic [VOL_W-1:0] pulse_one;
    logic [VOL_W-1:0] pulse_two;
    logic [SAW_W-1:0] saw;
  } levels_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_action;
  logic [ADDR_W-1:0]   in_address;
  logic [DATA_W-1:0]   in_data;
  logic                out_valid;
  logic                out_stall;
  logic [VOL_W-1:0]    out_pulse_one_level;
  logic [VOL_W-1:0]    out_pulse_two_level;
  logic [SAW_W-1:0]    out_saw_level;
  logic                cfg_write_en;
  logic                cfg_wdata;

  logic                swap_lines;
  logic [VOL_W-1:0]    p_volume [2];
  logic [DUTY_W-1:0]   p_duty [2];
  logic                p_constant [2];
  logic [PERIOD_W-1:0] p_period [2];
  logic                p_enable [2];
  logic [TIMER_W-1:0]  p_timer [2];
  logic [PHASE_W-1:0]  p_phase [2];
  logic [VOL_W-1:0]    p_level [2];
  logic [RATE_W-1:0]   s_rate;
  logic [PERIOD_W-1:0] s_period;
  logic                s_enable;
  logic [TIMER_W-1:0]  s_timer;
  logic [PHASE_W-1:0]  s_phase;
  logic [SAW_W-1:0]    s_accum;
  logic [SAW_W-1:0]    s_level;

  levels_t expected_levels [$];
  int      mismatch_count;
  int      results_seen;
  int      tick_count;
  int      write_count;
  int      send_idle_pct;
  int      recv_idle_pct;

  pulse_saw_sound_generator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_address          (in_address),
    .in_data             (in_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pulse_one_level (out_pulse_one_level),
    .out_pulse_two_level (out_pulse_two_level),
    .out_saw_level       (out_saw_level),
    .cfg_write_en        (cfg_write_en),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void clear_sound_state();
    swap_lines = 1'b0;
    for (int c = 0; c < 2; c++) begin
      p_volume[c]   = '0;
      p_duty[c]     = DUTY_W'(1);
      p_constant[c] = 1'b0;
      p_period[c]   = '0;
      p_enable[c]   = 1'b0;
      p_timer[c]    = TIMER_W'(1);
      p_phase[c]    = '0;
      p_level[c]    = '0;
    end
    s_rate   = '0;
    s_period = '0;
    s_enable = 1'b0;
    s_timer  = TIMER_W'(1);
    s_phase  = '0;
    s_accum  = '0;
    s_level  = '0;
  endfunction

  function automatic void apply_bus_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] dat);
    logic [1:0] sel;
    logic [3:0] page;
    int         c;
    sel  = swap_lines ? {addr[0], addr[1]} : addr[1:0];
    page = addr[15:12];
    if (page == PAGE_PULSE_ONE || page == PAGE_PULSE_TWO) begin
      c = (page == PAGE_PULSE_ONE) ? 0 : 1;
      case (sel)
        REG_CTRL: begin
          p_volume[c]   = dat[3:0];
          p_duty[c]     = dat[6:4];
          p_constant[c] = dat[7];
        end
        REG_PERIOD_LO: p_period[c][7:0] = dat;
        REG_PERIOD_HI: begin
          p_period[c][11:8] = dat[3:0];
          p_enable[c]       = dat[7];
        end
        default: ;
      endcase
    end else if (page == PAGE_SAW) begin
      case (sel)
        REG_CTRL:      s_rate = dat[5:0];
        REG_PERIOD_LO: s_period[7:0] = dat;
        REG_PERIOD_HI: begin
          s_period[11:8] = dat[3:0];
          s_enable       = dat[7];
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void advance_pulse(int c);
    p_timer[c] = p_timer[c] - 1'b1;
    if (p_timer[c] == '0) begin
      p_phase[c] = p_phase[c] + 1'b1;
      p_timer[c] = {1'b0, p_period[c]} + 1'b1;
      if (p_enable[c])
        p_level[c] = (p_constant[c] || p_phase[c] <= {1'b0, p_duty[c]}) ? p_volume[c] : '0;
    end
    if (!p_enable[c])
      p_level[c] = '0;
  endfunction

  function automatic void advance_saw();
    s_timer = s_timer - 1'b1;
    if (s_timer == '0) begin
      s_timer = {1'b0, s_period} + 1'b1;
      if (s_phase != '0 && !s_phase[0])
        s_accum = s_accum + {2'b00, s_rate};
      s_phase = s_phase + 1'b1;
      if (s_phase == SAW_PHASE_END) begin
        s_phase = '0;
        s_accum = '0;
      end
      if (s_enable)
        s_level = s_accum;
    end
  endfunction

  function automatic levels_t predict_levels(logic act, logic [ADDR_W-1:0] addr,
                                             logic [DATA_W-1:0] dat);
    levels_t lv;
    if (act == ACT_WRITE) begin
      apply_bus_write(addr, dat);
    end else begin
      advance_pulse(0);
      advance_pulse(1);
      advance_saw();
    end
    lv.pulse_one = p_level[0];
    lv.pulse_two = p_level[1];
    lv.saw       = s_level;
    return lv;
  endfunction

  function automatic logic [ADDR_W-1:0] reg_addr(logic [3:0] page, logic [9:0] mirror,
                                                 logic [1:0] sel);
    return {page, mirror, swap_lines ? {sel[0], sel[1]} : sel};
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_levels
    levels_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_levels.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result transfer with nothing expected", $realtime);
        mismatch_count++;
      end else begin
        want = expected_levels.pop_front();
        check_field("pulse_one_level", int'(want.pulse_one), int'(out_pulse_one_level));
        check_field("pulse_two_level", int'(want.pulse_two), int'(out_pulse_two_level));
        check_field("saw_level", int'(want.saw), int'(out_saw_level));
      end
    end
  end

  task automatic send_item(logic act, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] dat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= act;
    in_address <= addr;
    in_data    <= dat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_levels.push_back(predict_levels(act, addr, dat));
    if (act == ACT_TICK)
      tick_count++;
    else
      write_count++;
  endtask

  task automatic set_line_swap(logic v);
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_wdata    <= v;
    @(posedge clk);
    swap_lines = v;
    cfg_write_en <= 1'b0;
  endtask

  task automatic test_register_decode();
    send_item(ACT_WRITE, reg_addr(PAGE_PULSE_ONE, 10'h000, REG_CTRL), 8'hFF);
    send_item(ACT_WRITE, reg_addr(PAGE_PULSE_ONE, 10'h000, REG_PERIOD_LO), 8'h00);
    send_item(ACT_WRITE, reg_addr(PAGE_PULSE_ONE, 10'h000, REG_PERIOD_HI), 8'h80);
    send_item(ACT_WRITE, reg_addr(PAGE_PULSE_TWO, 10'h001, REG_CTRL), 8'h3F);
    send_item(ACT_WRITE, reg_addr(PAGE_PULSE_TWO, 10'h3FE, REG_PERIOD_LO), 8'h01);
    send_item(ACT_WRITE, reg_addr(PAGE_PULSE_TWO, 10'h000, REG_PERIOD_HI), 8'h80);
    send_item(ACT_WRITE, reg_addr(PAGE_SAW, 10'h000, REG_CTRL), 8'hFF);
    send_item(ACT_WRITE, reg_addr(PAGE_SAW, 10'h3FF, REG_PERIOD_LO), 8'h00);
    send_item(ACT_WRITE, reg_addr(PAGE_SAW, 10'h000, REG_PERIOD_HI), 8'h80);
    send_item(ACT_WRITE, reg_addr(PAGE_SAW, 10'h000, REG_UNUSED), 8'hFF);
    send_item(ACT_WRITE, reg_addr(PAGE_NONE_LOW, 10'h000, REG_CTRL), 8'hFF);
    send_item(ACT_WRITE, reg_addr(PAGE_NONE_HIGH, 10'h3FF, REG_PERIOD_HI), 8'hFF);
    send_item(ACT_WRITE, '0, '0);
  endtask

  task automatic test_channel_ticks();
    send_item(ACT_TICK, '1, '1);
    send_item(ACT_TICK, '0, '0);
    repeat (7) send_item(ACT_TICK, ADDR_W'($urandom), DATA_W'($urandom));
    send_item(ACT_WRITE, reg_addr(PAGE_SAW, 10'h000, REG_PERIOD_HI), 8'h00);
    repeat (2) send_item(ACT_TICK, ADDR_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic random_sound_item();
    int                pick;
    logic [3:0]        page;
    logic [1:0]        sel;
    logic [DATA_W-1:0] dat;
    logic [ADDR_W-1:0] addr;
    logic              wide_period;
    pick        = $urandom_range(99);
    addr        = ADDR_W'($urandom);
    dat         = DATA_W'($urandom);
    wide_period = 1'b0;
    if (pick < 60) begin
      send_item(ACT_TICK, addr, dat);
    end else if (pick < 95) begin
      case ($urandom_range(2))
        0:       page = PAGE_PULSE_ONE;
        1:       page = PAGE_PULSE_TWO;
        default: page = PAGE_SAW;
      endcase
      case ($urandom_range(19))
        0:             sel = REG_UNUSED;
        1, 2, 3, 4, 5: sel = REG_CTRL;
        6, 7, 8, 9:    sel = REG_PERIOD_LO;
        default:       sel = REG_PERIOD_HI;
      endcase
      if (sel == REG_PERIOD_LO && $urandom_range(9) != 0)
        dat = DATA_W'($urandom_range(15));
      if (sel == REG_PERIOD_HI) begin
        dat[7] = ($urandom_range(3) != 0);
        if ($urandom_range(9) != 0)
          dat[3:0] = '0;
        else
          wide_period = (dat[3:0] != '0);
      end
      send_item(ACT_WRITE, reg_addr(page, addr[11:2], sel), dat);
      // drop a long period again before any tick can load it
      if (wide_period) begin
        dat[3:0] = '0;
        send_item(ACT_WRITE, reg_addr(page, addr[11:2], sel), dat);
      end
    end else begin
      send_item(ACT_WRITE, addr, dat);
    end
  endtask

  task automatic test_random_sound(logic swap, int send_pct, int recv_pct, int count);
    set_line_swap(swap);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) random_sound_item();
  endtask

  initial begin
    #2_000_000;
    $display("timeout: transfers stopped before the run ended");
    $display("pulse_saw_sound_generator_tb: FAIL");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_action    <= ACT_WRITE;
    in_address   <= '0;
    in_data      <= '0;
    out_stall    <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_wdata    <= 1'b0;
    clear_sound_state();
    mismatch_count = 0;
    results_seen   = 0;
    tick_count     = 0;
    write_count    = 0;
    send_idle_pct  = 17;
    recv_idle_pct  = 78;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_line_swap(1'b0);
    test_register_decode();
    test_channel_ticks();
    test_random_sound(1'b1, 17, 78, 375);
    test_random_sound(1'b0, 78, 17, 375);
    test_random_sound(1'b1, 0, 0, 375);

    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d ticks and %0d register writes, %0d results checked,",
             tick_count, write_count, results_seen);
    $display("with both address line orders and three sender/receiver idle mixes.");
    if (mismatch_count == 0 && expected_levels.size() == 0)
      $display("pulse_saw_sound_generator_tb: PASS");
    else
      $display("pulse_saw_sound_generator_tb: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/psg_pkg.sv
rtl/psg_decode.sv
rtl/psg_pulse.sv
rtl/psg_saw.sv
rtl/pulse_saw_sound_generator.sv
tb/pulse_saw_sound_generator_tb.sv
